@@ design/atce_pkg.sv @@
package atce_pkg;

    localparam int DEF_MAX_COLUMNS = 128;
    localparam int DEF_MAX_ROWS    = 64;
    localparam int DEF_PARAM_SLOTS = 8;

    localparam int QUEUE_DEPTH = 2;
    localparam int CFG_INDEX_W = 2;
    localparam int CFG_DATA_W  = 8;

    localparam logic [CFG_INDEX_W-1:0] REG_COLUMNS = 2'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_ROWS    = 2'd1;

    localparam logic [7:0] COLUMNS_RESET = 8'd80;
    localparam logic [6:0] ROWS_RESET    = 7'd25;

    localparam logic [7:0] CODE_ESC   = 8'h1B;
    localparam logic [7:0] CODE_CR    = 8'h0D;
    localparam logic [7:0] CODE_LF    = 8'h0A;
    localparam logic [7:0] CODE_BS    = 8'h08;
    localparam logic [7:0] CODE_TAB   = 8'h09;
    localparam logic [7:0] CODE_DEL   = 8'h7F;
    localparam logic [7:0] CODE_SPACE = 8'h20;
    localparam logic [7:0] CODE_SEMI  = 8'h3B;
    localparam logic [7:0] CODE_QUERY = 8'h3F;
    localparam logic [7:0] CODE_LBR   = 8'h5B;
    localparam logic [7:0] CODE_SAVE  = 8'h37;
    localparam logic [7:0] CODE_REST  = 8'h38;
    localparam logic [7:0] CODE_ZERO  = 8'h30;
    localparam logic [7:0] CODE_NINE  = 8'h39;

    localparam logic [7:0] FIN_UP    = 8'h41;
    localparam logic [7:0] FIN_DOWN  = 8'h42;
    localparam logic [7:0] FIN_RIGHT = 8'h43;
    localparam logic [7:0] FIN_LEFT  = 8'h44;
    localparam logic [7:0] FIN_POS_H = 8'h48;
    localparam logic [7:0] FIN_POS_F = 8'h66;
    localparam logic [7:0] FIN_ERASE = 8'h4A;
    localparam logic [7:0] FIN_EOL   = 8'h4B;
    localparam logic [7:0] FIN_SGR   = 8'h6D;
    localparam logic [7:0] FIN_SAVE  = 8'h73;
    localparam logic [7:0] FIN_REST  = 8'h75;

    localparam int TAB_STEP = 8;
    localparam int TAB_MASK = ~7;
    localparam logic [15:0] ERASE_ALL = 16'd2;

    localparam logic [15:0] SGR_FG_LO  = 16'd30;
    localparam logic [15:0] SGR_FG_HI  = 16'd37;
    localparam logic [15:0] SGR_FG_DEF = 16'd39;
    localparam logic [15:0] SGR_BG_LO  = 16'd40;
    localparam logic [15:0] SGR_BG_HI  = 16'd47;
    localparam logic [15:0] SGR_BG_DEF = 16'd49;

    localparam logic [2:0] BLANK_FG = 3'd7;
    localparam logic [2:0] BLANK_BG = 3'd0;

    typedef struct packed {
        logic [2:0] bg;
        logic [2:0] fg;
        logic [7:0] ch;
    } cell_t;

    localparam cell_t BLANK_CELL = '{bg: BLANK_BG, fg: BLANK_FG, ch: CODE_SPACE};

    typedef enum logic [1:0] {
        MODE_NORMAL,
        MODE_ESCAPE,
        MODE_CSI
    } parse_mode_t;

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_READ,
        ST_FINAL,
        ST_SGR,
        ST_SCROLL_RD,
        ST_SCROLL_WR,
        ST_BLANK
    } back_state_t;

    typedef struct packed {
        logic       is_read;
        logic [7:0] data;
        logic [6:0] col;
        logic [5:0] row;
        logic       k_esc;
        logic       k_cr;
        logic       k_lf;
        logic       k_bs;
        logic       k_tab;
        logic       k_ctrl;
        logic       k_digit;
        logic       k_semi;
        logic       k_skip;
        logic       k_lbr;
        logic       k_save;
        logic       k_rest;
    } cmd_t;

    typedef struct packed {
        logic valid;
        cmd_t cmd;
    } q_head_t;

    typedef struct packed {
        logic init_done;
    } back_status_t;

endpackage

@@ design/ansi_terminal_cell_engine.sv @@
// byte-at-a-time vt100 subset terminal over a character-cell store. after reset busy stays high
// while the store is cleared one cell a cycle. an item is taken when start is high and busy low;
// a two-entry queue sits in front of the executing back end, and busy is high while that queue is
// full or the store is being cleared. a cell read goes through a registered memory read; a scroll
// copies each cell up one row, a read and then a write, and then blanks the last row; a csi final
// byte passes through a final state, then blanks cells for an erase or applies each parameter
// in turn for sgr.
// each result is on the outputs for exactly one cycle with done high and cannot be held off.
module ansi_terminal_cell_engine #(
    parameter int MAX_COLUMNS = atce_pkg::DEF_MAX_COLUMNS,
    parameter int MAX_ROWS    = atce_pkg::DEF_MAX_ROWS,
    parameter int PARAM_SLOTS = atce_pkg::DEF_PARAM_SLOTS
) (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             start,
    output logic                             busy,
    input  logic                             op,
    input  logic [7:0]                       data_byte,
    input  logic [6:0]                       read_column,
    input  logic [5:0]                       read_row,
    output logic                             done,
    output logic [7:0]                       cell_char,
    output logic [2:0]                       cell_fg,
    output logic [2:0]                       cell_bg,
    output logic [6:0]                       cursor_column,
    output logic [5:0]                       cursor_line,
    input  logic                             cfg_valid,
    output logic                             cfg_ready,
    input  logic [atce_pkg::CFG_INDEX_W-1:0] cfg_index,
    input  logic [atce_pkg::CFG_DATA_W-1:0]  cfg_data
);

    atce_pkg::q_head_t      head;
    atce_pkg::back_status_t status;
    logic                   pop;

    atce_front u_front (
        .clk         (clk),
        .rst_n       (rst_n),
        .start       (start),
        .op          (op),
        .data_byte   (data_byte),
        .read_column (read_column),
        .read_row    (read_row),
        .busy        (busy),
        .status      (status),
        .pop         (pop),
        .head        (head)
    );

    atce_back #(
        .MAX_COLUMNS (MAX_COLUMNS),
        .MAX_ROWS    (MAX_ROWS),
        .PARAM_SLOTS (PARAM_SLOTS)
    ) u_back (
        .clk           (clk),
        .rst_n         (rst_n),
        .head          (head),
        .pop           (pop),
        .status        (status),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data),
        .done          (done),
        .cell_char     (cell_char),
        .cell_fg       (cell_fg),
        .cell_bg       (cell_bg),
        .cursor_column (cursor_column),
        .cursor_line   (cursor_line)
    );

endmodule

@@ design/atce_front.sv @@
module atce_front (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   start,
    input  logic                   op,
    input  logic [7:0]             data_byte,
    input  logic [6:0]             read_column,
    input  logic [5:0]             read_row,
    output logic                   busy,
    input  atce_pkg::back_status_t status,
    input  logic                   pop,
    output atce_pkg::q_head_t      head
);

    localparam int QW = (atce_pkg::QUEUE_DEPTH > 1) ? $clog2(atce_pkg::QUEUE_DEPTH) : 1;
    localparam int NW = $clog2(atce_pkg::QUEUE_DEPTH + 1);

    atce_pkg::cmd_t  q_reg [atce_pkg::QUEUE_DEPTH];
    logic [QW-1:0]   wr_ptr_reg, wr_ptr_next;
    logic [QW-1:0]   rd_ptr_reg, rd_ptr_next;
    logic [NW-1:0]   count_reg, count_next;
    atce_pkg::cmd_t  cmd;
    logic            push;
    logic            do_pop;

    // byte classes do not depend on parser mode
    always_comb
    begin
        cmd         = '0;
        cmd.is_read = op;
        cmd.data    = data_byte;
        cmd.col     = read_column;
        cmd.row     = read_row;
        cmd.k_esc   = data_byte == atce_pkg::CODE_ESC;
        cmd.k_cr    = data_byte == atce_pkg::CODE_CR;
        cmd.k_lf    = data_byte == atce_pkg::CODE_LF;
        cmd.k_bs    = data_byte == atce_pkg::CODE_BS || data_byte == atce_pkg::CODE_DEL;
        cmd.k_tab   = data_byte == atce_pkg::CODE_TAB;
        cmd.k_ctrl  = data_byte < atce_pkg::CODE_SPACE;
        cmd.k_digit = data_byte inside {[atce_pkg::CODE_ZERO:atce_pkg::CODE_NINE]};
        cmd.k_semi  = data_byte == atce_pkg::CODE_SEMI;
        cmd.k_skip  = data_byte inside {atce_pkg::CODE_QUERY, atce_pkg::CODE_SPACE};
        cmd.k_lbr   = data_byte == atce_pkg::CODE_LBR;
        cmd.k_save  = data_byte == atce_pkg::CODE_SAVE;
        cmd.k_rest  = data_byte == atce_pkg::CODE_REST;
    end

    assign busy       = (count_reg == NW'(atce_pkg::QUEUE_DEPTH)) || !status.init_done;
    assign push       = start && !busy;
    assign do_pop     = pop && (count_reg != '0);
    assign head.valid = count_reg != '0;
    assign head.cmd   = q_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == QW'(atce_pkg::QUEUE_DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_pop)
        begin
            rd_ptr_next = (rd_ptr_reg == QW'(atce_pkg::QUEUE_DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (push && !do_pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (do_pop && !push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            q_reg[wr_ptr_reg] <= cmd;
        end
    end

endmodule

@@ design/atce_back.sv @@
module atce_back #(
    parameter int MAX_COLUMNS = atce_pkg::DEF_MAX_COLUMNS,
    parameter int MAX_ROWS    = atce_pkg::DEF_MAX_ROWS,
    parameter int PARAM_SLOTS = atce_pkg::DEF_PARAM_SLOTS
) (
    input  logic                             clk,
    input  logic                             rst_n,
    input  atce_pkg::q_head_t                head,
    output logic                             pop,
    output atce_pkg::back_status_t           status,
    input  logic                             cfg_valid,
    output logic                             cfg_ready,
    input  logic [atce_pkg::CFG_INDEX_W-1:0] cfg_index,
    input  logic [atce_pkg::CFG_DATA_W-1:0]  cfg_data,
    output logic                             done,
    output logic [7:0]                       cell_char,
    output logic [2:0]                       cell_fg,
    output logic [2:0]                       cell_bg,
    output logic [6:0]                       cursor_column,
    output logic [5:0]                       cursor_line
);

    localparam int CW    = $clog2(MAX_COLUMNS);
    localparam int RW    = $clog2(MAX_ROWS);
    localparam int DEPTH = MAX_COLUMNS * MAX_ROWS;
    localparam int AW    = $clog2(DEPTH);
    localparam int PW    = $clog2(PARAM_SLOTS);
    localparam int NW    = $clog2(PARAM_SLOTS + 1);

    atce_pkg::cell_t mem [DEPTH];
    atce_pkg::cell_t rd_data_reg;
    logic            mem_we, mem_re;
    logic [AW-1:0]   mem_waddr, mem_raddr;
    atce_pkg::cell_t mem_wdata;

    atce_pkg::back_state_t state_reg, state_next;
    atce_pkg::parse_mode_t mode_reg, mode_next;

    logic [15:0]   plist_reg [PARAM_SLOTS];
    logic [15:0]   plist_next [PARAM_SLOTS];
    logic [NW-1:0] pcount_reg, pcount_next;
    logic [15:0]   accum_reg, accum_next;
    logic          seen_reg, seen_next;
    logic [7:0]    final_reg, final_next;
    logic [PW-1:0] sgr_idx_reg, sgr_idx_next;

    logic [CW-1:0] cur_col_reg, cur_col_next, saved_col_reg, saved_col_next;
    logic [RW-1:0] cur_row_reg, cur_row_next, saved_row_reg, saved_row_next;
    logic [2:0]    pen_fg_reg, pen_fg_next, pen_bg_reg, pen_bg_next;
    logic [7:0]    cols_reg, cols_next;
    logic [6:0]    rows_reg, rows_next;

    logic [CW-1:0] sw_col_reg, sw_col_next;
    logic [RW-1:0] sw_row_reg, sw_row_next;
    logic          sw_line_reg, sw_line_next;
    logic          oor_reg, oor_next;
    logic [AW-1:0] clr_reg, clr_next;

    logic            done_reg;
    atce_pkg::cell_t res_cell_reg, res_cell;
    logic [6:0]      res_col_reg;
    logic [5:0]      res_row_reg;
    logic            finish;

    logic [CW-1:0] last_col, new_last_col;
    logic [RW-1:0] last_row, new_last_row;
    atce_pkg::cmd_t h;
    logic          go;
    logic          printable;
    logic          lf_now, scroll_now, csi_final;
    logic          scroll_last, blank_end, sgr_last;
    logic [15:0]   p0, p1, sgr_p;
    logic [CW:0]   tab_next;
    logic [16:0]   sum_row, sum_col;
    logic [15:0]   pos_row, pos_col;
    logic          cfg_write;

    function automatic logic [CW-1:0] eff_last_col(input logic [7:0] v);
        logic [CW-1:0] r;
        if (v == 8'd0)
            r = '0;
        else if ({1'b0, v} > 9'(MAX_COLUMNS))
            r = CW'(MAX_COLUMNS - 1);
        else
            r = CW'(v - 8'd1);
        return r;
    endfunction

    function automatic logic [RW-1:0] eff_last_row(input logic [6:0] v);
        logic [RW-1:0] r;
        if (v == 7'd0)
            r = '0;
        else if ({1'b0, v} > 8'(MAX_ROWS))
            r = RW'(MAX_ROWS - 1);
        else
            r = RW'(v - 7'd1);
        return r;
    endfunction

    function automatic logic [AW-1:0] cell_addr(input logic [RW-1:0] r, input logic [CW-1:0] c);
        return AW'(r) * AW'(MAX_COLUMNS) + AW'(c);
    endfunction

    assign last_col  = eff_last_col(cols_reg);
    assign last_row  = eff_last_row(rows_reg);
    assign h         = head.cmd;
    assign go        = (state_reg == atce_pkg::ST_IDLE) && head.valid;
    assign pop       = go;
    assign cfg_ready = 1'b1;
    assign cfg_write = cfg_valid;
    assign status.init_done = state_reg != atce_pkg::ST_CLEAR;

    assign printable  = !(h.k_esc || h.k_cr || h.k_lf || h.k_bs || h.k_tab || h.k_ctrl);
    assign lf_now     = !h.is_read && (mode_reg == atce_pkg::MODE_NORMAL)
                        && (h.k_lf || (printable && cur_col_reg >= last_col));
    assign scroll_now = lf_now && (cur_row_reg >= last_row);
    assign csi_final  = !h.is_read && (mode_reg == atce_pkg::MODE_CSI)
                        && !(h.k_digit || h.k_semi || h.k_skip);

    assign scroll_last = (sw_col_reg == last_col) && ((sw_row_reg + RW'(1)) == last_row);
    assign blank_end   = (sw_col_reg == last_col) && (sw_line_reg || sw_row_reg == last_row);
    assign sgr_last    = (NW'(sgr_idx_reg) + NW'(1)) >= pcount_reg;

    // missing or zero parameters count as one
    assign p0 = (pcount_reg >= NW'(1) && plist_reg[0] != 16'd0) ? plist_reg[0] : 16'd1;
    assign p1 = (pcount_reg >= NW'(2) && plist_reg[1] != 16'd0) ? plist_reg[1] : 16'd1;
    assign sgr_p   = plist_reg[sgr_idx_reg];
    assign tab_next = ({1'b0, cur_col_reg} + (CW+1)'(atce_pkg::TAB_STEP))
                      & (CW+1)'(atce_pkg::TAB_MASK);
    assign sum_row = 17'(cur_row_reg) + {1'b0, p0};
    assign sum_col = 17'(cur_col_reg) + {1'b0, p0};
    assign pos_row = p0 - 16'd1;
    assign pos_col = p1 - 16'd1;

    always_comb
    begin
        new_last_col = last_col;
        new_last_row = last_row;
        if (cfg_index == atce_pkg::REG_COLUMNS)
            new_last_col = eff_last_col(cfg_data);
        else if (cfg_index == atce_pkg::REG_ROWS)
            new_last_row = eff_last_row(cfg_data[6:0]);
    end

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            atce_pkg::ST_CLEAR:
            begin
                if (clr_reg == AW'(DEPTH - 1))
                    state_next = atce_pkg::ST_IDLE;
            end
            atce_pkg::ST_IDLE:
            begin
                if (go)
                begin
                    if (h.is_read)
                        state_next = atce_pkg::ST_READ;
                    else if (scroll_now)
                        state_next = (last_row == '0) ? atce_pkg::ST_BLANK
                                                      : atce_pkg::ST_SCROLL_RD;
                    else if (csi_final)
                        state_next = atce_pkg::ST_FINAL;
                end
            end
            atce_pkg::ST_READ:
                state_next = atce_pkg::ST_IDLE;
            atce_pkg::ST_FINAL:
            begin
                if (final_reg == atce_pkg::FIN_ERASE || final_reg == atce_pkg::FIN_EOL)
                    state_next = atce_pkg::ST_BLANK;
                else if (final_reg == atce_pkg::FIN_SGR)
                    state_next = atce_pkg::ST_SGR;
                else
                    state_next = atce_pkg::ST_IDLE;
            end
            atce_pkg::ST_SGR:
            begin
                if (sgr_last)
                    state_next = atce_pkg::ST_IDLE;
            end
            atce_pkg::ST_SCROLL_RD:
                state_next = atce_pkg::ST_SCROLL_WR;
            atce_pkg::ST_SCROLL_WR:
                state_next = scroll_last ? atce_pkg::ST_BLANK : atce_pkg::ST_SCROLL_RD;
            atce_pkg::ST_BLANK:
            begin
                if (blank_end)
                    state_next = atce_pkg::ST_IDLE;
            end
            default:
                state_next = atce_pkg::ST_IDLE;
        endcase
    end

    // datapath and memory control
    always_comb
    begin
        mode_next      = mode_reg;
        plist_next     = plist_reg;
        pcount_next    = pcount_reg;
        accum_next     = accum_reg;
        seen_next      = seen_reg;
        final_next     = final_reg;
        sgr_idx_next   = sgr_idx_reg;
        cur_col_next   = cur_col_reg;
        cur_row_next   = cur_row_reg;
        saved_col_next = saved_col_reg;
        saved_row_next = saved_row_reg;
        pen_fg_next    = pen_fg_reg;
        pen_bg_next    = pen_bg_reg;
        cols_next      = cols_reg;
        rows_next      = rows_reg;
        sw_col_next    = sw_col_reg;
        sw_row_next    = sw_row_reg;
        sw_line_next   = sw_line_reg;
        oor_next       = oor_reg;
        clr_next       = clr_reg;
        mem_we         = 1'b0;
        mem_re         = 1'b0;
        mem_waddr      = cell_addr(cur_row_reg, cur_col_reg);
        mem_raddr      = cell_addr(sw_row_reg + RW'(1), sw_col_reg);
        mem_wdata      = '{bg: pen_bg_reg, fg: pen_fg_reg, ch: atce_pkg::CODE_SPACE};
        finish         = 1'b0;
        res_cell       = '0;
        case (state_reg)
            atce_pkg::ST_CLEAR:
            begin
                mem_we    = 1'b1;
                mem_waddr = clr_reg;
                mem_wdata = atce_pkg::BLANK_CELL;
                clr_next  = clr_reg + 1'b1;
            end
            atce_pkg::ST_IDLE:
            begin
                if (go && h.is_read)
                begin
                    mem_re    = 1'b1;
                    mem_raddr = AW'(AW'(h.row) * AW'(MAX_COLUMNS)) + AW'(h.col);
                    oor_next  = !((9'(h.col) < 9'(MAX_COLUMNS)) && (8'(h.row) < 8'(MAX_ROWS)));
                end
                else if (go)
                begin
                    case (mode_reg)
                        atce_pkg::MODE_NORMAL:
                        begin
                            if (h.k_esc)
                                mode_next = atce_pkg::MODE_ESCAPE;
                            else if (h.k_cr)
                                cur_col_next = '0;
                            else if (h.k_bs)
                            begin
                                if (cur_col_reg != '0)
                                    cur_col_next = cur_col_reg - 1'b1;
                            end
                            else if (h.k_tab)
                                cur_col_next = (tab_next > (CW+1)'(last_col)) ? last_col
                                                                              : CW'(tab_next);
                            else if (printable)
                            begin
                                mem_we         = 1'b1;
                                mem_wdata.ch   = h.data;
                                cur_col_next   = (cur_col_reg >= last_col) ? '0
                                                                           : cur_col_reg + 1'b1;
                            end
                            // line feed, direct or after a wrap
                            if (lf_now)
                            begin
                                if (scroll_now)
                                begin
                                    sw_col_next  = '0;
                                    sw_row_next  = (last_row == '0) ? last_row : '0;
                                    sw_line_next = 1'b1;
                                end
                                else
                                    cur_row_next = cur_row_reg + 1'b1;
                            end
                            finish = !scroll_now;
                        end
                        atce_pkg::MODE_ESCAPE:
                        begin
                            pcount_next = '0;
                            accum_next  = '0;
                            seen_next   = 1'b0;
                            mode_next   = h.k_lbr ? atce_pkg::MODE_CSI : atce_pkg::MODE_NORMAL;
                            if (h.k_save)
                            begin
                                saved_col_next = cur_col_reg;
                                saved_row_next = cur_row_reg;
                            end
                            else if (h.k_rest)
                            begin
                                cur_col_next = (saved_col_reg > last_col) ? last_col
                                                                          : saved_col_reg;
                                cur_row_next = (saved_row_reg > last_row) ? last_row
                                                                          : saved_row_reg;
                            end
                            finish = 1'b1;
                        end
                        atce_pkg::MODE_CSI:
                        begin
                            if (h.k_digit)
                            begin
                                accum_next = (accum_reg << 3) + (accum_reg << 1)
                                             + {12'd0, h.data[3:0]};
                                seen_next  = 1'b1;
                            end
                            else if (h.k_semi || (csi_final && (seen_reg || pcount_reg == '0)))
                            begin
                                // pushes past the last slot are dropped
                                if (pcount_reg < NW'(PARAM_SLOTS))
                                begin
                                    plist_next[pcount_reg[PW-1:0]] = seen_reg ? accum_reg : 16'd0;
                                    pcount_next = pcount_reg + 1'b1;
                                    accum_next  = '0;
                                    seen_next   = 1'b0;
                                end
                            end
                            final_next = h.data;
                            finish     = !csi_final;
                        end
                        default:
                        begin
                            mode_next = atce_pkg::MODE_NORMAL;
                            finish    = 1'b1;
                        end
                    endcase
                end
            end
            atce_pkg::ST_READ:
            begin
                finish   = 1'b1;
                res_cell = oor_reg ? atce_pkg::BLANK_CELL : rd_data_reg;
            end
            atce_pkg::ST_FINAL:
            begin
                mode_next    = atce_pkg::MODE_NORMAL;
                sw_col_next  = cur_col_reg;
                sw_row_next  = cur_row_reg;
                sw_line_next = 1'b0;
                sgr_idx_next = '0;
                if (final_reg != atce_pkg::FIN_SGR)
                begin
                    pcount_next = '0;
                    accum_next  = '0;
                    seen_next   = 1'b0;
                end
                case (final_reg)
                    atce_pkg::FIN_UP:
                        cur_row_next = (p0 > 16'(cur_row_reg)) ? '0 : cur_row_reg - RW'(p0);
                    atce_pkg::FIN_DOWN:
                        cur_row_next = (sum_row > 17'(last_row)) ? last_row : RW'(sum_row);
                    atce_pkg::FIN_RIGHT:
                        cur_col_next = (sum_col > 17'(last_col)) ? last_col : CW'(sum_col);
                    atce_pkg::FIN_LEFT:
                        cur_col_next = (p0 > 16'(cur_col_reg)) ? '0 : cur_col_reg - CW'(p0);
                    atce_pkg::FIN_POS_H, atce_pkg::FIN_POS_F:
                    begin
                        cur_row_next = (pos_row > 16'(last_row)) ? last_row : RW'(pos_row);
                        cur_col_next = (pos_col > 16'(last_col)) ? last_col : CW'(pos_col);
                    end
                    atce_pkg::FIN_ERASE:
                    begin
                        if (plist_reg[0] == atce_pkg::ERASE_ALL)
                        begin
                            sw_col_next  = '0;
                            sw_row_next  = '0;
                            cur_col_next = '0;
                            cur_row_next = '0;
                        end
                    end
                    atce_pkg::FIN_EOL:
                        sw_line_next = 1'b1;
                    atce_pkg::FIN_SAVE:
                    begin
                        saved_col_next = cur_col_reg;
                        saved_row_next = cur_row_reg;
                    end
                    atce_pkg::FIN_REST:
                    begin
                        cur_col_next = (saved_col_reg > last_col) ? last_col : saved_col_reg;
                        cur_row_next = (saved_row_reg > last_row) ? last_row : saved_row_reg;
                    end
                    default:
                    begin
                    end
                endcase
                finish = !(final_reg == atce_pkg::FIN_ERASE || final_reg == atce_pkg::FIN_EOL
                           || final_reg == atce_pkg::FIN_SGR);
            end
            atce_pkg::ST_SGR:
            begin
                if (sgr_p == 16'd0)
                begin
                    pen_fg_next = atce_pkg::BLANK_FG;
                    pen_bg_next = atce_pkg::BLANK_BG;
                end
                else if (sgr_p inside {[atce_pkg::SGR_FG_LO:atce_pkg::SGR_FG_HI]})
                    pen_fg_next = 3'(sgr_p - atce_pkg::SGR_FG_LO);
                else if (sgr_p == atce_pkg::SGR_FG_DEF)
                    pen_fg_next = atce_pkg::BLANK_FG;
                else if (sgr_p inside {[atce_pkg::SGR_BG_LO:atce_pkg::SGR_BG_HI]})
                    pen_bg_next = 3'(sgr_p - atce_pkg::SGR_BG_LO);
                else if (sgr_p == atce_pkg::SGR_BG_DEF)
                    pen_bg_next = atce_pkg::BLANK_BG;
                sgr_idx_next = sgr_idx_reg + 1'b1;
                if (sgr_last)
                begin
                    pcount_next = '0;
                    accum_next  = '0;
                    seen_next   = 1'b0;
                    finish      = 1'b1;
                end
            end
            atce_pkg::ST_SCROLL_RD:
                mem_re = 1'b1;
            atce_pkg::ST_SCROLL_WR:
            begin
                mem_we    = 1'b1;
                mem_waddr = cell_addr(sw_row_reg, sw_col_reg);
                mem_wdata = rd_data_reg;
                if (sw_col_reg == last_col)
                begin
                    sw_col_next = '0;
                    sw_row_next = scroll_last ? last_row : sw_row_reg + 1'b1;
                end
                else
                    sw_col_next = sw_col_reg + 1'b1;
            end
            atce_pkg::ST_BLANK:
            begin
                mem_we    = 1'b1;
                mem_waddr = cell_addr(sw_row_reg, sw_col_reg);
                if (blank_end)
                    finish = 1'b1;
                else if (sw_col_reg == last_col)
                begin
                    sw_col_next = '0;
                    sw_row_next = sw_row_reg + 1'b1;
                end
                else
                    sw_col_next = sw_col_reg + 1'b1;
            end
            default:
            begin
            end
        endcase
        if (cfg_write)
        begin
            if (cfg_index == atce_pkg::REG_COLUMNS)
                cols_next = cfg_data;
            else if (cfg_index == atce_pkg::REG_ROWS)
                rows_next = cfg_data[6:0];
            if (cfg_index == atce_pkg::REG_COLUMNS || cfg_index == atce_pkg::REG_ROWS)
            begin
                cur_col_next = (cur_col_reg > new_last_col) ? new_last_col : cur_col_reg;
                cur_row_next = (cur_row_reg > new_last_row) ? new_last_row : cur_row_reg;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= atce_pkg::ST_CLEAR;
            mode_reg      <= atce_pkg::MODE_NORMAL;
            for (int i = 0; i < PARAM_SLOTS; i++)
                plist_reg[i] <= '0;
            pcount_reg    <= '0;
            accum_reg     <= '0;
            seen_reg      <= 1'b0;
            sgr_idx_reg   <= '0;
            cur_col_reg   <= '0;
            cur_row_reg   <= '0;
            saved_col_reg <= '0;
            saved_row_reg <= '0;
            pen_fg_reg    <= atce_pkg::BLANK_FG;
            pen_bg_reg    <= atce_pkg::BLANK_BG;
            cols_reg      <= atce_pkg::COLUMNS_RESET;
            rows_reg      <= atce_pkg::ROWS_RESET;
            sw_col_reg    <= '0;
            sw_row_reg    <= '0;
            sw_line_reg   <= 1'b0;
            clr_reg       <= '0;
            done_reg      <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            mode_reg      <= mode_next;
            plist_reg     <= plist_next;
            pcount_reg    <= pcount_next;
            accum_reg     <= accum_next;
            seen_reg      <= seen_next;
            sgr_idx_reg   <= sgr_idx_next;
            cur_col_reg   <= cur_col_next;
            cur_row_reg   <= cur_row_next;
            saved_col_reg <= saved_col_next;
            saved_row_reg <= saved_row_next;
            pen_fg_reg    <= pen_fg_next;
            pen_bg_reg    <= pen_bg_next;
            cols_reg      <= cols_next;
            rows_reg      <= rows_next;
            sw_col_reg    <= sw_col_next;
            sw_row_reg    <= sw_row_next;
            sw_line_reg   <= sw_line_next;
            clr_reg       <= clr_next;
            done_reg      <= finish;
        end
    end

    always_ff @(posedge clk)
    begin
        final_reg <= final_next;
        oor_reg   <= oor_next;
        if (finish)
        begin
            res_cell_reg <= res_cell;
            res_col_reg  <= 7'(cur_col_next);
            res_row_reg  <= 6'(cur_row_next);
        end
    end

    always_ff @(posedge clk)
    begin
        if (mem_we)
            mem[mem_waddr] <= mem_wdata;
        if (mem_re)
            rd_data_reg <= mem[mem_raddr];
    end

    assign done          = done_reg;
    assign cell_char     = res_cell_reg.ch;
    assign cell_fg       = res_cell_reg.fg;
    assign cell_bg       = res_cell_reg.bg;
    assign cursor_column = res_col_reg;
    assign cursor_line   = res_row_reg;

endmodule
